// File: rtl/nsvcd_pkg.sv
package nsvcd_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int MAX_RESULTS = 3;
    localparam int HDR_LAST = 6;
    localparam int SYNC_SKIP = 10;
    localparam int AUX_LAST = 5;
    localparam int AUX_EXTRA = 6;

    localparam logic [15:0] SYNC_WORD_NS = 16'h4E53;
    localparam logic [15:0] SYNC_WORD_EF = 16'hEFBE;
    localparam logic [7:0] SIG_N = 8'h4E;
    localparam logic [7:0] SIG_S_UPPER = 8'h53;
    localparam logic [7:0] SIG_V = 8'h56;
    localparam logic [7:0] SIG_S_LOWER = 8'h73;

    localparam logic [3:0] KIND_HEADER = 4'd0;
    localparam logic [3:0] KIND_SYNC = 4'd1;
    localparam logic [3:0] KIND_AUX = 4'd2;
    localparam logic [3:0] KIND_VIDEO = 4'd3;
    localparam logic [3:0] KIND_AUDIO = 4'd4;
    localparam logic [3:0] KIND_VIDEO_DROP = 4'd5;
    localparam logic [3:0] KIND_AUDIO_DROP = 4'd6;
    localparam logic [3:0] KIND_VIDEO_EMPTY = 4'd7;
    localparam logic [3:0] KIND_AUDIO_EMPTY = 4'd8;

    localparam logic CFG_VIDEO_EN = 1'b0;
    localparam logic CFG_AUDIO_EN = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_SYNC,
        PH_AUX,
        PH_AUXSKIP,
        PH_VIDEO,
        PH_AUDIO
    } t_phase;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [3:0]  kind;
        logic        packet_end;
        logic [19:0] packet_length;
        logic [31:0] chunk_index;
        logic        sync_lost;
        logic        length_error;
        logic        run_last;
    } t_result;

endpackage

// File: rtl/nsv_chunk_deframer.sv
// Channel   Direction  Handshake                  Payload
// s         in         i_s_tvalid / o_s_tready    i_s_tdata: data_byte
// m         out        o_m_tvalid / i_m_tready    tdata, tuser, tlast: one result word
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while o_s_tready is high; its state update completes in the same cycle.
// Each byte yields one to three result words, written into a four-entry result queue.
// The queue drains one word per cycle while i_m_tready is high, so each marker word also holds back the input.
// A byte is accepted only while at least three queue entries are free.
// Reset is synchronous and active low; the block accepts words from the first edge after
// its release and holds both ready outputs low while reset is asserted.
module nsv_chunk_deframer
    import nsvcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [7:0] out_byte, [27:8] packet_length,
                                     // [59:28] chunk_index, [63:60] zero
    output logic [6:0]  o_m_tuser,   // [3:0] kind, [4] packet_end, [5] sync_lost,
                                     // [6] length_error
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_byte_cnt, n_byte_cnt;
    logic [7:0]  r_hb [HDR_LAST];
    logic [7:0]  n_hb [HDR_LAST];
    logic        r_resync, n_resync;
    logic [19:0] r_video_rem, n_video_rem;
    logic [15:0] r_audio_rem, n_audio_rem;
    logic [15:0] r_aux_rem, n_aux_rem;
    logic [31:0] r_chunk, n_chunk;
    logic [19:0] r_video_len, n_video_len;
    logic [15:0] r_audio_len, n_audio_len;
    logic        r_video_en, r_audio_en;

    t_result     r_fifo [FIFO_DEPTH];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count;

    t_result     n_res [MAX_RESULTS];
    logic [1:0]  n_num;
    logic        s_acc, m_pop;
    logic        sync_flag, err_flag, pend, go_video, go_audio, mark_v, mark_a;
    logic [3:0]  kind;
    logic [19:0] plen;
    logic [15:0] aux_full;
    logic [16:0] aux_dec;
    t_result     marker;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_pop = o_m_tvalid && i_m_tready;
    assign o_s_tready = i_rst_n && (r_count <= 3'(FIFO_DEPTH - MAX_RESULTS));
    assign o_cfg_ready = i_rst_n;

    always_comb begin
        n_phase = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_hb = r_hb;
        n_resync = r_resync;
        n_video_rem = r_video_rem;
        n_audio_rem = r_audio_rem;
        n_aux_rem = r_aux_rem;
        n_chunk = r_chunk;
        n_video_len = r_video_len;
        n_audio_len = r_audio_len;
        sync_flag = 1'b0;
        err_flag = 1'b0;
        pend = 1'b0;
        plen = '0;
        kind = KIND_HEADER;
        go_video = 1'b0;
        go_audio = 1'b0;
        mark_v = 1'b0;
        mark_a = 1'b0;
        aux_full = {i_s_tdata, r_aux_rem[7:0]};
        aux_dec = {1'b0, aux_full} + 17'(AUX_EXTRA);

        unique case (r_phase)
            PH_HDR: begin
                kind = KIND_HEADER;
                if (r_byte_cnt < 4'(HDR_LAST)) begin
                    n_hb[r_byte_cnt[2:0]] = i_s_tdata;
                end
                if (r_byte_cnt == 4'd1 && !r_resync
                        && {r_hb[0], i_s_tdata} != SYNC_WORD_NS
                        && {r_hb[0], i_s_tdata} != SYNC_WORD_EF) begin
                    sync_flag = 1'b1;
                end
                if (r_byte_cnt == 4'(HDR_LAST)) begin
                    n_byte_cnt = '0;
                    if (!r_resync && r_hb[0] == SIG_N && r_hb[1] == SIG_S_UPPER
                            && r_hb[2] == SIG_V && r_hb[3] == SIG_S_LOWER) begin
                        n_resync = 1'b1;
                        n_phase = PH_SYNC;
                    end else begin
                        n_resync = 1'b0;
                        n_video_rem = {r_hb[4], r_hb[3], r_hb[2][7:4]};
                        n_audio_rem = {i_s_tdata, r_hb[5]};
                        n_video_len = n_video_rem;
                        n_audio_len = n_audio_rem;
                        if (r_hb[2][3:0] != 4'd0) begin
                            n_phase = PH_AUX;
                            n_aux_rem = '0;
                        end else begin
                            go_video = 1'b1;
                        end
                    end
                end else begin
                    n_byte_cnt = r_byte_cnt + 4'd1;
                end
            end
            PH_SYNC: begin
                kind = KIND_SYNC;
                n_byte_cnt = r_byte_cnt + 4'd1;
                if (n_byte_cnt >= 4'(SYNC_SKIP)) begin
                    n_phase = PH_HDR;
                    n_byte_cnt = '0;
                end
            end
            PH_AUX: begin
                kind = KIND_AUX;
                if (r_byte_cnt == 4'd0) begin
                    n_aux_rem = {8'd0, i_s_tdata};
                end else if (r_byte_cnt == 4'd1) begin
                    n_aux_rem = aux_full;
                    if (r_video_rem < {3'd0, aux_dec}) begin
                        n_video_rem = '0;
                        err_flag = 1'b1;
                    end else begin
                        n_video_rem = r_video_rem - {3'd0, aux_dec};
                    end
                    n_video_len = n_video_rem;
                end
                if (r_byte_cnt >= 4'(AUX_LAST)) begin
                    n_byte_cnt = '0;
                    if (n_aux_rem == 16'd0) begin
                        go_video = 1'b1;
                    end else begin
                        n_phase = PH_AUXSKIP;
                    end
                end else begin
                    n_byte_cnt = r_byte_cnt + 4'd1;
                end
            end
            PH_AUXSKIP: begin
                kind = KIND_AUX;
                if (r_aux_rem != 16'd0) begin
                    n_aux_rem = r_aux_rem - 16'd1;
                end
                if (n_aux_rem == 16'd0) begin
                    go_video = 1'b1;
                end
            end
            PH_VIDEO: begin
                kind = r_video_en ? KIND_VIDEO : KIND_VIDEO_DROP;
                plen = r_video_len;
                if (r_video_rem != 20'd0) begin
                    n_video_rem = r_video_rem - 20'd1;
                end
                pend = (n_video_rem == 20'd0);
                go_audio = pend;
            end
            PH_AUDIO: begin
                kind = r_audio_en ? KIND_AUDIO : KIND_AUDIO_DROP;
                plen = {4'd0, r_audio_len};
                if (r_audio_rem != 16'd0) begin
                    n_audio_rem = r_audio_rem - 16'd1;
                end
                pend = (n_audio_rem == 16'd0);
                if (pend) begin
                    n_chunk = r_chunk + 32'd1;
                    n_phase = PH_HDR;
                    n_byte_cnt = '0;
                    n_resync = 1'b0;
                end
            end
            default: begin
                n_phase = PH_HDR;
                n_byte_cnt = '0;
            end
        endcase

        if (go_video) begin
            if (n_video_rem == 20'd0) begin
                mark_v = r_video_en;
                go_audio = 1'b1;
            end else begin
                n_phase = PH_VIDEO;
            end
        end
        if (go_audio) begin
            if (n_audio_rem == 16'd0) begin
                mark_a = r_audio_en;
                n_chunk = r_chunk + 32'd1;
                n_phase = PH_HDR;
                n_byte_cnt = '0;
                n_resync = 1'b0;
            end else begin
                n_phase = PH_AUDIO;
            end
        end

        marker = '{out_byte: 8'd0, kind: KIND_VIDEO_EMPTY, packet_end: 1'b1,
                   packet_length: 20'd0, chunk_index: r_chunk, sync_lost: 1'b0,
                   length_error: 1'b0, run_last: 1'b0};
        n_res[0] = '{out_byte: i_s_tdata, kind: kind, packet_end: pend,
                     packet_length: plen, chunk_index: r_chunk, sync_lost: sync_flag,
                     length_error: err_flag, run_last: 1'b0};
        n_res[1] = marker;
        n_res[2] = marker;
        n_num = 2'd1;
        if (mark_v) begin
            n_num = 2'd2;
        end
        if (mark_a) begin
            n_res[n_num].kind = KIND_AUDIO_EMPTY;
            n_num = n_num + 2'd1;
        end
        n_res[n_num - 2'd1].run_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_byte_cnt <= '0;
            r_resync <= 1'b0;
            r_video_rem <= '0;
            r_audio_rem <= '0;
            r_aux_rem <= '0;
            r_chunk <= '0;
            r_video_len <= '0;
            r_audio_len <= '0;
        end else if (s_acc) begin
            r_phase <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_resync <= n_resync;
            r_video_rem <= n_video_rem;
            r_audio_rem <= n_audio_rem;
            r_aux_rem <= n_aux_rem;
            r_chunk <= n_chunk;
            r_video_len <= n_video_len;
            r_audio_len <= n_audio_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_hb <= n_hb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_en <= 1'b1;
            r_audio_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_VIDEO_EN: r_video_en <= i_cfg_data;
                CFG_AUDIO_EN: r_audio_en <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (s_acc) begin
                r_wr_ptr <= r_wr_ptr + n_num;
            end
            if (m_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (s_acc ? {1'b0, n_num} : 3'd0) - (m_pop ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int j = 0; j < MAX_RESULTS; j++) begin
                if (2'(j) < n_num) begin
                    r_fifo[r_wr_ptr + 2'(j)] <= n_res[j];
                end
            end
        end
    end

    assign o_m_tvalid = (r_count != 3'd0);
    assign o_m_tdata = {4'd0, r_fifo[r_rd_ptr].chunk_index,
                        r_fifo[r_rd_ptr].packet_length, r_fifo[r_rd_ptr].out_byte};
    assign o_m_tuser = {r_fifo[r_rd_ptr].length_error, r_fifo[r_rd_ptr].sync_lost,
                        r_fifo[r_rd_ptr].packet_end, r_fifo[r_rd_ptr].kind};
    assign o_m_tlast = r_fifo[r_rd_ptr].run_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_sync_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_phase == PH_SYNC && !m_pop) |=> r_count == $past(r_count) + 3'd1)
        else $error("dropped sync byte did not give exactly one word");

    a_hdr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HDR |-> r_byte_cnt <= 4'(HDR_LAST))
        else $error("header byte counter out of range");

    a_chunk_hold: assert property (@(posedge i_clk)
        (i_rst_n && !s_acc) |=> $stable(r_chunk))
        else $error("chunk counter moved without an accepted byte");

endmodule

// File: tb/nsv_chunk_deframer_tb.sv
`timescale 1ns / 1ps

module nsv_chunk_deframer_tb;
    import nsvcd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic [6:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic        i_cfg_data;

    nsv_chunk_deframer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_result     pending_words[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          idling_on = 1'b0;

    // Mirror of the deframer state.
    logic        video_on;
    logic        audio_on;
    t_phase      parse_phase;
    logic [4:0]  parse_count;
    logic [7:0]  hdr_store [6];
    logic        after_resync;
    logic [19:0] video_left;
    logic [19:0] video_len;
    logic [15:0] audio_left;
    logic [19:0] audio_len;
    logic [15:0] aux_left;
    logic [31:0] chunk_no;

    function automatic void push_word(logic [7:0] b, logic [3:0] kind, logic pkt_end,
                                      logic [19:0] len, logic lost, logic len_err);
        t_result w;
        w.out_byte      = b;
        w.kind          = kind;
        w.packet_end    = pkt_end;
        w.packet_length = len;
        w.chunk_index   = chunk_no;
        w.sync_lost     = lost;
        w.length_error  = len_err;
        w.run_last      = 1'b0;
        pending_words.push_back(w);
    endfunction

    function automatic void close_chunk();
        chunk_no     = chunk_no + 32'd1;
        parse_phase  = PH_HDR;
        parse_count  = '0;
        after_resync = 1'b0;
    endfunction

    function automatic void enter_audio();
        if (audio_left == 0) begin
            if (audio_on)
                push_word(8'd0, KIND_AUDIO_EMPTY, 1'b1, 20'd0, 1'b0, 1'b0);
            close_chunk();
        end else begin
            parse_phase = PH_AUDIO;
        end
    endfunction

    function automatic void enter_video();
        if (video_left == 0) begin
            if (video_on)
                push_word(8'd0, KIND_VIDEO_EMPTY, 1'b1, 20'd0, 1'b0, 1'b0);
            enter_audio();
        end else begin
            parse_phase = PH_VIDEO;
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic    lost;
        logic    len_err;
        logic    pkt_end;
        int      cut;
        t_result w;
        case (parse_phase)
            PH_HDR: begin
                lost = 1'b0;
                if (parse_count < 6)
                    hdr_store[parse_count] = b;
                if (parse_count == 1 && !after_resync &&
                    {hdr_store[0], b} != SYNC_WORD_NS && {hdr_store[0], b} != SYNC_WORD_EF)
                    lost = 1'b1;
                push_word(b, KIND_HEADER, 1'b0, 20'd0, lost, 1'b0);
                if (parse_count >= HDR_LAST) begin
                    if (!after_resync && hdr_store[0] == SIG_N &&
                        hdr_store[1] == SIG_S_UPPER && hdr_store[2] == SIG_V &&
                        hdr_store[3] == SIG_S_LOWER) begin
                        after_resync = 1'b1;
                        parse_phase  = PH_SYNC;
                        parse_count  = '0;
                    end else begin
                        after_resync = 1'b0;
                        parse_count  = '0;
                        video_left   = {hdr_store[4], hdr_store[3], hdr_store[2][7:4]};
                        audio_left   = {b, hdr_store[5]};
                        video_len    = video_left;
                        audio_len    = {4'd0, audio_left};
                        if (hdr_store[2][3:0] != 4'd0) begin
                            parse_phase = PH_AUX;
                            aux_left    = '0;
                        end else begin
                            enter_video();
                        end
                    end
                end else begin
                    parse_count = parse_count + 5'd1;
                end
            end
            PH_SYNC: begin
                push_word(b, KIND_SYNC, 1'b0, 20'd0, 1'b0, 1'b0);
                parse_count = parse_count + 5'd1;
                if (parse_count >= SYNC_SKIP) begin
                    parse_phase = PH_HDR;
                    parse_count = '0;
                end
            end
            PH_AUX: begin
                len_err = 1'b0;
                if (parse_count == 0) begin
                    aux_left = {8'd0, b};
                end else if (parse_count == 1) begin
                    aux_left[15:8] = b;
                    cut = int'(aux_left) + AUX_EXTRA;
                    if (int'(video_left) < cut) begin
                        video_left = '0;
                        len_err    = 1'b1;
                    end else begin
                        video_left = 20'(int'(video_left) - cut);
                    end
                    video_len = video_left;
                end
                push_word(b, KIND_AUX, 1'b0, 20'd0, 1'b0, len_err);
                if (parse_count >= AUX_LAST) begin
                    parse_count = '0;
                    if (aux_left == 0)
                        enter_video();
                    else
                        parse_phase = PH_AUXSKIP;
                end else begin
                    parse_count = parse_count + 5'd1;
                end
            end
            PH_AUXSKIP: begin
                push_word(b, KIND_AUX, 1'b0, 20'd0, 1'b0, 1'b0);
                if (aux_left > 0)
                    aux_left = aux_left - 16'd1;
                if (aux_left == 0)
                    enter_video();
            end
            PH_VIDEO: begin
                if (video_left > 0)
                    video_left = video_left - 20'd1;
                pkt_end = (video_left == 0);
                push_word(b, video_on ? KIND_VIDEO : KIND_VIDEO_DROP, pkt_end, video_len,
                          1'b0, 1'b0);
                if (pkt_end)
                    enter_audio();
            end
            default: begin
                if (audio_left > 0)
                    audio_left = audio_left - 16'd1;
                pkt_end = (audio_left == 0);
                push_word(b, audio_on ? KIND_AUDIO : KIND_AUDIO_DROP, pkt_end, audio_len,
                          1'b0, 1'b0);
                if (pkt_end)
                    close_chunk();
            end
        endcase
        w = pending_words.pop_back();
        w.run_last = 1'b1;
        pending_words.push_back(w);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: word expected none actual tdata %0h tuser %0h",
                         $time, o_m_tdata, o_m_tuser);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                check_field("out_byte", want.out_byte, o_m_tdata[7:0]);
                check_field("packet_length", want.packet_length, o_m_tdata[27:8]);
                check_field("chunk_index", want.chunk_index, o_m_tdata[59:28]);
                check_field("tdata padding", 32'd0, o_m_tdata[63:60]);
                check_field("kind", want.kind, o_m_tuser[3:0]);
                check_field("packet_end", want.packet_end, o_m_tuser[4]);
                check_field("sync_lost", want.sync_lost, o_m_tuser[5]);
                check_field("length_error", want.length_error, o_m_tuser[6]);
                check_field("run_last", want.run_last, o_m_tlast);
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= !(idling_on && $urandom_range(99) < 10);
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        if (idling_on && $urandom_range(99) < 10) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        do @(posedge i_clk); while (!o_s_tready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_byte(8'($urandom));
    endtask

    task automatic send_header(input logic [15:0] word, input logic [19:0] vlen,
                               input logic [3:0] aux_flag, input logic [15:0] alen);
        send_byte(word[15:8]);
        send_byte(word[7:0]);
        send_byte({vlen[3:0], aux_flag});
        send_byte(vlen[11:4]);
        send_byte(vlen[19:12]);
        send_byte(alen[7:0]);
        send_byte(alen[15:8]);
    endtask

    task automatic send_aux(input logic [15:0] skip);
        send_byte(skip[7:0]);
        send_byte(skip[15:8]);
        send_random(AUX_LAST - 1);
        send_random(skip);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_VIDEO_EN)
            video_on = value;
        else
            audio_on = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_chunk(input bit noisy);
        logic [15:0] word;
        logic [19:0] vlen;
        logic [15:0] alen;
        logic [15:0] skip;
        logic [3:0]  aux_flag;
        int          video_bytes;
        if (!noisy && $urandom_range(99) < 20) begin
            send_header(SYNC_WORD_NS, {12'd0, SIG_V[7:4]} | 20'(SIG_S_LOWER) << 4,
                        SIG_V[3:0], 16'($urandom));
            send_random(SYNC_SKIP);
        end
        case ($urandom_range(2))
            0:       word = SYNC_WORD_NS;
            1:       word = SYNC_WORD_EF;
            default: word = 16'($urandom);
        endcase
        if (noisy)
            word = 16'($urandom);
        vlen = 20'($urandom_range(0, 14));
        if ($urandom_range(9) == 0)
            vlen = 20'($urandom_range(0, 40));
        alen     = 16'($urandom_range(0, 10));
        aux_flag = ($urandom_range(99) < 30) ? 4'($urandom_range(1, 15)) : 4'd0;
        skip     = 16'($urandom_range(0, 3));
        send_header(word, vlen, aux_flag, alen);
        video_bytes = int'(vlen);
        if (aux_flag != 4'd0) begin
            send_aux(skip);
            video_bytes = (vlen > skip + AUX_EXTRA) ? vlen - skip - AUX_EXTRA : 0;
        end
        send_random(video_bytes);
        send_random(alen);
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) send_chunk($urandom_range(99) < 15);
    endtask

    task automatic test_empty_chunk();
        send_header(SYNC_WORD_EF, 20'd0, 4'd0, 16'd0);
    endtask

    task automatic test_sync_header();
        send_header(SYNC_WORD_NS, {12'd0, SIG_V[7:4]} | 20'(SIG_S_LOWER) << 4,
                    SIG_V[3:0], 16'h00FF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_random(SYNC_SKIP - 2);
        send_header(16'h0000, 20'd1, 4'd0, 16'd2);
        send_random(3);
    endtask

    task automatic test_plain_ns_header();
        send_header(SYNC_WORD_NS, 20'd2, 4'd0, 16'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
    endtask

    task automatic test_lost_sync_and_saturation();
        send_header(16'hFF00, 20'd0, 4'd1, 16'd0);
        send_aux(16'd0);
    endtask

    task automatic test_aux_skip();
        send_header(SYNC_WORD_EF, 20'd9, 4'hF, 16'd1);
        send_aux(16'd2);
        send_random(2);
    endtask

    task automatic test_streams_disabled();
        wait_drain();
        write_reg(CFG_VIDEO_EN, 1'b0);
        write_reg(CFG_AUDIO_EN, 1'b0);
        send_header(SYNC_WORD_EF, 20'd0, 4'd0, 16'd0);
        send_header(SYNC_WORD_EF, 20'd2, 4'd0, 16'd2);
        send_random(4);
        wait_drain();
        write_reg(CFG_VIDEO_EN, 1'b1);
        write_reg(CFG_AUDIO_EN, 1'b1);
    endtask

    // The header after a sync header is taken as a plain one even when it spells the
    // sync word again, so it opens an aux block and a long video packet.
    task automatic test_repeated_sync();
        send_header(SYNC_WORD_NS, {12'd0, SIG_V[7:4]} | 20'(SIG_S_LOWER) << 4,
                    SIG_V[3:0], 16'd0);
        send_random(SYNC_SKIP);
        send_header(SYNC_WORD_NS, {12'd0, SIG_V[7:4]} | 20'(SIG_S_LOWER) << 4,
                    SIG_V[3:0], 16'd1);
        send_aux(16'd1);
        send_random(4);
    endtask

    task automatic test_random_stream();
        random_phase(25);
        wait_drain();
        idling_on = 1'b1;
        write_reg(CFG_VIDEO_EN, 1'b0);
        write_reg(CFG_AUDIO_EN, 1'b0);
        random_phase(25);
        wait_drain();
        write_reg(CFG_VIDEO_EN, 1'b1);
        random_phase(25);
        wait_drain();
        write_reg(CFG_VIDEO_EN, 1'b0);
        write_reg(CFG_AUDIO_EN, 1'b1);
        random_phase(25);
        wait_drain();
        write_reg(CFG_VIDEO_EN, 1'b1);
        random_phase(10);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = 1'b0;
        i_cfg_data   = 1'b0;
        video_on     = 1'b1;
        audio_on     = 1'b1;
        parse_phase  = PH_HDR;
        parse_count  = '0;
        foreach (hdr_store[k]) hdr_store[k] = '0;
        after_resync = 1'b0;
        video_left   = '0;
        video_len    = '0;
        audio_left   = '0;
        audio_len    = '0;
        aux_left     = '0;
        chunk_no     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_VIDEO_EN, 1'b1);
        write_reg(CFG_AUDIO_EN, 1'b1);
        test_empty_chunk();
        test_sync_header();
        test_plain_ns_header();
        test_lost_sync_and_saturation();
        test_aux_skip();
        test_streams_disabled();
        test_random_stream();
        test_repeated_sync();
        wait_drain();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/nsvcd_pkg.sv
rtl/nsv_chunk_deframer.sv
tb/nsv_chunk_deframer_tb.sv
